// ----- hdl/olki_pkg.sv -----
// ----------------------------------------------------------------------------
// olki_pkg
// Shared types and codes for the ordered keyed list store.
// ----------------------------------------------------------------------------
package olki_pkg;

    localparam int DATA_W        = 32;
    localparam int ACT_W         = 2;
    localparam int STATUS_W      = 3;
    localparam int POS_W         = 5;
    localparam int DEPTH_DEFAULT = 32;
    localparam int MAX_RESULTS   = 32;

    // Actions.
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_AFTER  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_BEFORE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // Per-cell load selects; at most one is set in a cycle.
    typedef struct packed {
        logic load_new;
        logic take_left;
        logic take_right;
        logic take_head;
    } cell_ctl_t;

endpackage

// ----- hdl/olki_cell.sv -----
// ----------------------------------------------------------------------------
// olki_cell
// One storage cell of the list: holds a value, compares it with the key and
// loads from its neighbors when the list shifts or rotates.
// ----------------------------------------------------------------------------
module olki_cell
(
    input  logic                              clk,
    input  olki_pkg::cell_ctl_t               ctl,
    input  logic signed [olki_pkg::DATA_W-1:0] new_val,
    input  logic signed [olki_pkg::DATA_W-1:0] left_val,
    input  logic signed [olki_pkg::DATA_W-1:0] right_val,
    input  logic signed [olki_pkg::DATA_W-1:0] head_val,
    input  logic signed [olki_pkg::DATA_W-1:0] key,
    output logic signed [olki_pkg::DATA_W-1:0] val,
    output logic                              match
);

    logic signed [olki_pkg::DATA_W-1:0] val_reg;
    logic signed [olki_pkg::DATA_W-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.load_new)
        begin
            val_next = new_val;
        end
        else if (ctl.take_left)
        begin
            val_next = left_val;
        end
        else if (ctl.take_right)
        begin
            val_next = right_val;
        end
        else if (ctl.take_head)
        begin
            val_next = head_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val   = val_reg;
    assign match = (val_reg == key);

endmodule

// ----- hdl/olki_chain.sv -----
// ----------------------------------------------------------------------------
// olki_chain
// Row of list cells wired to their neighbors, head at cell zero.
// ----------------------------------------------------------------------------
module olki_chain
#(
    parameter int DEPTH = olki_pkg::DEPTH_DEFAULT
)
(
    input  logic                               clk,
    input  olki_pkg::cell_ctl_t                ctl [DEPTH],
    input  logic signed [olki_pkg::DATA_W-1:0] new_val,
    input  logic signed [olki_pkg::DATA_W-1:0] key,
    output logic        [DEPTH-1:0]            match,
    output logic signed [olki_pkg::DATA_W-1:0] head_val
);

    logic signed [olki_pkg::DATA_W-1:0] cell_val [DEPTH];

    assign head_val = cell_val[0];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [olki_pkg::DATA_W-1:0] left_in;
        logic signed [olki_pkg::DATA_W-1:0] right_in;

        // The head never shifts in from the left and the tail never takes
        // from the right, so the open ends are tied to harmless sources.
        if (i == 0)
        begin : g_head
            assign left_in = new_val;
        end
        else
        begin : g_mid
            assign left_in = cell_val[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_in = cell_val[0];
        end
        else
        begin : g_body
            assign right_in = cell_val[i+1];
        end

        olki_cell u_cell
        (
            .clk       (clk),
            .ctl       (ctl[i]),
            .new_val   (new_val),
            .left_val  (left_in),
            .right_val (right_in),
            .head_val  (cell_val[0]),
            .key       (key),
            .val       (cell_val[i]),
            .match     (match[i])
        );
    end

endmodule

// ----- hdl/ordered_list_keyed_insert.sv -----
// ----------------------------------------------------------------------------
// ordered_list_keyed_insert
// Ordered list of up to DEPTH signed values with keyed insert and read-out.
// ----------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low; action,
// key and value are sampled on that edge. Every result appears on status,
// element, position and last for exactly one cycle with strobe high; the
// receiver cannot stall, so results are never held back.
// Append and the two keyed inserts pass through the search and insert states:
// the search state registers the key match of every occupied cell, the
// insert state isolates the first match and shifts the tail of the chain by
// one cell. Their one result shows in the cycle in which busy drops, so the
// result overlaps the next accept.
// Read-out rotates the chain by one cell per cycle, emitting the head, and
// is busy until one full rotation (one result per cycle, at most 32 results);
// after the full rotation the list is back in its original order. An empty
// read-out gives one result in the cycle after the accept, without busy.
// Reset empties the list at once; cell contents are not cleared.
// ----------------------------------------------------------------------------
module ordered_list_keyed_insert
#(
    parameter int DEPTH = olki_pkg::DEPTH_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic        [olki_pkg::ACT_W-1:0]    action,
    input  logic signed [olki_pkg::DATA_W-1:0]   key,
    input  logic signed [olki_pkg::DATA_W-1:0]   value,
    output logic                                 strobe,
    output logic        [olki_pkg::STATUS_W-1:0] status,
    output logic signed [olki_pkg::DATA_W-1:0]   element,
    output logic        [olki_pkg::POS_W-1:0]    position,
    output logic                                 last
);

    localparam int OW = $clog2(DEPTH + 1);
    localparam int PW = (OW > olki_pkg::POS_W) ? OW : olki_pkg::POS_W;
    localparam int CW = (OW > 6) ? OW : 6;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SRCH = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;
    localparam logic [1:0] S_READ = 2'd3;

    logic [1:0]                          state_reg, state_next;
    logic [OW-1:0]                       occ_reg, occ_next;
    logic [OW-1:0]                       rd_cnt_reg, rd_cnt_next;
    logic [olki_pkg::ACT_W-1:0]          act_reg, act_next;
    logic signed [olki_pkg::DATA_W-1:0]  key_reg, key_next;
    logic signed [olki_pkg::DATA_W-1:0]  val_reg, val_next;
    logic [DEPTH-1:0]                    match_reg, match_next;
    logic                                strobe_reg, strobe_next;
    logic [olki_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic signed [olki_pkg::DATA_W-1:0]  element_reg, element_next;
    logic [olki_pkg::POS_W-1:0]          position_reg, position_next;
    logic                                last_reg, last_next;

    olki_pkg::cell_ctl_t                 ctl [DEPTH];
    logic [DEPTH-1:0]                    cell_match;
    logic signed [olki_pkg::DATA_W-1:0]  head_val;

    logic [DEPTH-1:0]                    occ_mask;
    logic [DEPTH-1:0]                    app_oh;
    logic [DEPTH-1:0]                    low_oh;
    logic [DEPTH-1:0]                    ge_mask;
    logic [DEPTH-1:0]                    at_oh;
    logic [DEPTH-1:0]                    shift_mask;
    logic [OW-1:0]                       at_bin;
    logic [OW-1:0]                       at_enc;
    logic                                found;
    logic                                full;
    logic [PW-1:0]                       at_ext;
    logic [PW-1:0]                       rd_ext;
    logic [CW-1:0]                       rd_wide;
    logic [CW-1:0]                       occ_wide;
    logic [CW-1:0]                       rd_limit;

    olki_chain #(.DEPTH(DEPTH)) u_chain
    (
        .clk      (clk),
        .ctl      (ctl),
        .new_val  (val_reg),
        .key      (key_reg),
        .match    (cell_match),
        .head_val (head_val)
    );

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            occ_mask[i] = (OW'(i) < occ_reg);
            app_oh[i]   = (OW'(i) == occ_reg);
        end
    end

    // Isolate the first match from the head, and everything from it on.
    assign low_oh  = match_reg & (~match_reg + DEPTH'(1));
    assign ge_mask = ~(low_oh - DEPTH'(1));
    assign found   = |match_reg;
    assign full    = (occ_reg == OW'(DEPTH));

    always_comb
    begin
        at_oh      = app_oh;
        shift_mask = '0;
        if (act_reg == olki_pkg::ACT_AFTER)
        begin
            at_oh      = low_oh << 1;
            shift_mask = ge_mask << 2;
        end
        else if (act_reg == olki_pkg::ACT_BEFORE)
        begin
            at_oh      = low_oh;
            shift_mask = ge_mask << 1;
        end
    end

    always_comb
    begin
        at_enc = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (at_oh[i])
            begin
                at_enc = at_enc | OW'(i);
            end
        end
    end

    assign at_bin   = (act_reg == olki_pkg::ACT_APPEND) ? occ_reg : at_enc;
    assign at_ext   = PW'(at_bin);
    assign rd_ext   = PW'(rd_cnt_reg);
    assign rd_wide  = CW'(rd_cnt_reg);
    assign occ_wide = CW'(occ_reg);
    assign rd_limit = (occ_wide < CW'(olki_pkg::MAX_RESULTS)) ?
                      occ_wide : CW'(olki_pkg::MAX_RESULTS);

    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        rd_cnt_next   = rd_cnt_reg;
        act_next      = act_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        match_next    = match_reg;
        strobe_next   = 1'b0;
        status_next   = status_reg;
        element_next  = element_reg;
        position_next = position_reg;
        last_next     = last_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            ctl[i] = '0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next = action;
                    key_next = key;
                    val_next = value;
                    if (action == olki_pkg::ACT_READ)
                    begin
                        if (occ_reg == '0)
                        begin
                            strobe_next   = 1'b1;
                            status_next   = olki_pkg::ST_EMPTY;
                            element_next  = '0;
                            position_next = '0;
                            last_next     = 1'b1;
                        end
                        else
                        begin
                            rd_cnt_next = '0;
                            state_next  = S_READ;
                        end
                    end
                    else
                    begin
                        state_next = S_SRCH;
                    end
                end
            end

            S_SRCH:
            begin
                match_next = cell_match & occ_mask;
                state_next = S_INS;
            end

            S_INS:
            begin
                strobe_next   = 1'b1;
                element_next  = '0;
                position_next = '0;
                last_next     = 1'b1;
                state_next    = S_IDLE;
                // A missing key wins over a full store.
                if ((act_reg != olki_pkg::ACT_APPEND) && !found)
                begin
                    status_next = olki_pkg::ST_NOT_FOUND;
                end
                else if (full)
                begin
                    status_next = olki_pkg::ST_FULL;
                end
                else
                begin
                    status_next   = olki_pkg::ST_INSERTED;
                    position_next = at_ext[olki_pkg::POS_W-1:0];
                    occ_next      = occ_reg + OW'(1);
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        ctl[i].load_new  = at_oh[i];
                        ctl[i].take_left = shift_mask[i];
                    end
                end
            end

            S_READ:
            begin
                // Rotate the occupied part of the chain toward the head.
                for (int i = 0; i < DEPTH; i++)
                begin
                    ctl[i].take_right = ((OW'(i) + OW'(1)) < occ_reg);
                    ctl[i].take_head  = ((OW'(i) + OW'(1)) == occ_reg);
                end
                if (rd_wide < rd_limit)
                begin
                    strobe_next   = 1'b1;
                    status_next   = olki_pkg::ST_READ;
                    element_next  = head_val;
                    position_next = rd_ext[olki_pkg::POS_W-1:0];
                    last_next     = ((rd_wide + CW'(1)) == rd_limit);
                end
                rd_cnt_next = rd_cnt_reg + OW'(1);
                if ((rd_cnt_reg + OW'(1)) == occ_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            occ_reg    <= '0;
            rd_cnt_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            rd_cnt_reg <= rd_cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        match_reg    <= match_next;
        status_reg   <= status_next;
        element_reg  <= element_next;
        position_reg <= position_next;
        last_reg     <= last_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign strobe   = strobe_reg;
    assign status   = status_reg;
    assign element  = element_reg;
    assign position = position_reg;
    assign last     = last_reg;

    // The insert step always produces its result in the following cycle.
    a_ins_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |=> strobe_reg)
        else $error("insert step finished without a result");

    // The list length only changes on the insert step.
    a_occ_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_INS) |=> $stable(occ_reg))
        else $error("occupancy changed outside the insert step");

    // A reported insertion grew the list by exactly one entry.
    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && (status_reg == olki_pkg::ST_INSERTED)) |->
        (occ_reg == ($past(occ_reg) + OW'(1))))
        else $error("inserted status without growth of the list");

    // The list never holds more than DEPTH entries.
    a_occ_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |=> (occ_reg <= OW'(DEPTH)))
        else $error("occupancy above capacity");

endmodule
